// File: sv/pstr_pkg.sv
// Shared types, sizes and helpers for the polyphase symbol timing recovery core.
// Used by pstr_ctrl, pstr_datapath and the top level; no dependencies.
package pstr_pkg;

  // Filter bank geometry
  localparam int NFILT        = 32;
  localparam int TAPS_PER_ARM = 16;
  localparam int LINE_DEPTH   = 64;

  localparam int ARM_W   = $clog2(NFILT);
  localparam int TAP_M_W = $clog2(TAPS_PER_ARM);
  localparam int TAP_AW  = ARM_W + TAP_M_W;
  localparam int TAP_DEPTH = NFILT * TAPS_PER_ARM;
  localparam int MAC_CW  = TAP_M_W + 1;
  localparam int LINE_AW = $clog2(LINE_DEPTH);
  localparam int FILL_W  = LINE_AW + 1;

  // Field widths
  localparam int SMP_W  = 16;
  localparam int TIDX_W = 9;
  localparam int ERR_W  = 32;
  localparam int RFR_W  = 21;
  localparam int PNOW_W = 23;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 21;

  // Internal number formats
  localparam int FRAC_W = 16;
  localparam int WRAP_B = ARM_W + FRAC_W;   // bit weight of one full phase wrap
  localparam int PH_W   = 30;               // wide phase during the loop passes
  localparam int RATE_W = 24;               // wide rate during the loop passes
  localparam int DA_W   = 19;               // loop increments
  localparam int W_W    = 12;               // wrap count of one symbol
  localparam int AGE_W  = 14;
  localparam int ACC_W  = 36;
  localparam int CNT_W  = 6;                // samples until next symbol
  localparam int SPS_W  = 5;
  localparam int OSPS_W = 3;
  localparam int GAIN_W = 16;
  localparam int MAXD_W = 20;
  localparam int RINT_W = 5;
  localparam int IPH_W  = 21;

  localparam logic signed [AGE_W-1:0] AGE_MAX = AGE_W'(LINE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(TAPS_PER_ARM);
  localparam logic signed [W_W+1:0] RELOAD_MAX = (W_W + 2)'(63);

  // Input functions
  typedef enum logic [1:0] {
    FN_PUSH = 2'd0,
    FN_TAP  = 2'd1,
    FN_DTAP = 2'd2,
    FN_NONE = 2'd3
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_SPS   = 3'd0,
    CFG_OSPS  = 3'd1,
    CFG_PGAIN = 3'd2,
    CFG_RGAIN = 3'd3,
    CFG_MAXD  = 3'd4,
    CFG_RINT  = 3'd5,
    CFG_IPH   = 3'd6,
    CFG_NONE  = 3'd7
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_MAC,
    ST_ROUND,
    ST_DSET,
    ST_DMAC,
    ST_DROUND,
    ST_GAIN_A,
    ST_GAIN_B,
    ST_LOOP,
    ST_FIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic push;
    logic tap_we;
    logic sym_start;
    logic wrap_start;
    logic load_out;
    logic deriv_start;
    logic calc_err;
    logic gain_a;
    logic gain_b;
    logic loop_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fire;
    logic mac_done;
    logic out_free;
    logic last_out;
    logic loop_done;
  } status_t;

  // Round half up from Q2.30 to Q1.15 and saturate
  function automatic logic signed [SMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = (acc + ACC_W'(16384)) >>> 15;
    if (t > ACC_W'(32767)) begin
      return 16'sh7fff;
    end else if (t < -ACC_W'(32768)) begin
      return 16'sh8000;
    end
    return t[SMP_W-1:0];
  endfunction

endpackage

// File: sv/polyphase_symbol_timing_recovery_core.sv
// Top level of the polyphase symbol timing recovery core.
// Depends on pstr_pkg, pstr_ctrl and pstr_datapath.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    func, sample, tap_index, tap_value
//  out      output     out_valid_o / out_stall_i  out_sample, timing_error, rate_frac,
//                                                 phase_now, last
//  cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A tap write or a push that does not end a symbol leaves the sequencer idle.
// A symbol push runs, for each output and then for the derivative arm, a
// 16-tap sweep through one multiply-accumulate unit, then sps loop passes.
// Reset clears the delay line (via a fill count) and loop state; config takes defaults.
// A stalled output beat holds the sequencer with the next arm result; the sweep waits.
module polyphase_symbol_timing_recovery_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         func_i,
  input  logic signed [pstr_pkg::SMP_W-1:0]  sample_i,
  input  logic [pstr_pkg::TIDX_W-1:0]        tap_index_i,
  input  logic signed [pstr_pkg::SMP_W-1:0]  tap_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pstr_pkg::SMP_W-1:0]  out_sample_o,
  output logic signed [pstr_pkg::ERR_W-1:0]  timing_error_o,
  output logic signed [pstr_pkg::RFR_W-1:0]  rate_frac_o,
  output logic signed [pstr_pkg::PNOW_W-1:0] phase_now_o,
  output logic                               last_o,
  input  logic                               cfg_we_i,
  input  logic [pstr_pkg::CFG_AW-1:0]        cfg_index_i,
  input  logic [pstr_pkg::CFG_DW-1:0]        cfg_wdata_i
);

  pstr_pkg::cmd_t    cmd;
  pstr_pkg::status_t status;

  pstr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pstr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .func_i         (func_i),
    .sample_i       (sample_i),
    .tap_index_i    (tap_index_i),
    .tap_value_i    (tap_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_sample_o   (out_sample_o),
    .timing_error_o (timing_error_o),
    .rate_frac_o    (rate_frac_o),
    .phase_now_o    (phase_now_o),
    .last_o         (last_o)
  );

endmodule

// File: sv/pstr_ctrl.sv
// Sequencer for the polyphase symbol timing recovery core.
// Depends on pstr_pkg; drives pstr_datapath through cmd_t, reads status_t.
module pstr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  pstr_pkg::status_t    status_i,
  output pstr_pkg::cmd_t       cmd_o
);

  pstr_pkg::state_e state_q, state_d;
  logic accept;

  assign accept = in_valid_i && (state_q == pstr_pkg::ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pstr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pstr_pkg::ST_IDLE: begin
        if (accept && func_i == pstr_pkg::FN_PUSH && status_i.fire) begin
          state_d = pstr_pkg::ST_WRAP;
        end
      end
      pstr_pkg::ST_WRAP:  state_d = pstr_pkg::ST_MAC;
      pstr_pkg::ST_MAC: begin
        if (status_i.mac_done) state_d = pstr_pkg::ST_ROUND;
      end
      pstr_pkg::ST_ROUND: begin
        if (status_i.out_free) begin
          state_d = status_i.last_out ? pstr_pkg::ST_DSET : pstr_pkg::ST_WRAP;
        end
      end
      pstr_pkg::ST_DSET:  state_d = pstr_pkg::ST_DMAC;
      pstr_pkg::ST_DMAC: begin
        if (status_i.mac_done) state_d = pstr_pkg::ST_DROUND;
      end
      pstr_pkg::ST_DROUND: state_d = pstr_pkg::ST_GAIN_A;
      pstr_pkg::ST_GAIN_A: state_d = pstr_pkg::ST_GAIN_B;
      pstr_pkg::ST_GAIN_B: state_d = pstr_pkg::ST_LOOP;
      pstr_pkg::ST_LOOP: begin
        if (status_i.loop_done) state_d = pstr_pkg::ST_FIN;
      end
      pstr_pkg::ST_FIN:   state_d = pstr_pkg::ST_IDLE;
      default:            state_d = pstr_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != pstr_pkg::ST_IDLE);
    case (state_q)
      pstr_pkg::ST_IDLE: begin
        cmd_o.push      = accept && func_i == pstr_pkg::FN_PUSH;
        cmd_o.tap_we    = accept && (func_i == pstr_pkg::FN_TAP ||
                                     func_i == pstr_pkg::FN_DTAP);
        cmd_o.sym_start = accept && func_i == pstr_pkg::FN_PUSH && status_i.fire;
      end
      pstr_pkg::ST_WRAP:   cmd_o.wrap_start  = 1'b1;
      pstr_pkg::ST_ROUND:  cmd_o.load_out    = status_i.out_free;
      pstr_pkg::ST_DSET:   cmd_o.deriv_start = 1'b1;
      pstr_pkg::ST_DROUND: cmd_o.calc_err    = 1'b1;
      pstr_pkg::ST_GAIN_A: cmd_o.gain_a      = 1'b1;
      pstr_pkg::ST_GAIN_B: cmd_o.gain_b      = 1'b1;
      pstr_pkg::ST_LOOP:   cmd_o.loop_step   = !status_i.loop_done;
      pstr_pkg::ST_FIN:    cmd_o.finish      = 1'b1;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // A symbol only starts from a sample push
  a_sym_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sym_start |-> cmd_o.push) else $error("symbol start without push");
  // After the final pass the core is ready again
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !in_stall_o) else $error("not idle after symbol");
  // Arm results go out only into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free) else $error("output overwritten");
`endif

endmodule

// File: sv/pstr_datapath.sv
// Datapath: delay line, tap stores, multiply-accumulate, loop filter, config registers.
// Depends on pstr_pkg; sequenced by pstr_ctrl.
module pstr_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pstr_pkg::cmd_t                    cmd_i,
  output pstr_pkg::status_t                 status_o,
  input  logic [1:0]                        func_i,
  input  logic signed [pstr_pkg::SMP_W-1:0] sample_i,
  input  logic [pstr_pkg::TIDX_W-1:0]       tap_index_i,
  input  logic signed [pstr_pkg::SMP_W-1:0] tap_value_i,
  input  logic                              cfg_we_i,
  input  logic [pstr_pkg::CFG_AW-1:0]       cfg_index_i,
  input  logic [pstr_pkg::CFG_DW-1:0]       cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pstr_pkg::SMP_W-1:0] out_sample_o,
  output logic signed [pstr_pkg::ERR_W-1:0] timing_error_o,
  output logic signed [pstr_pkg::RFR_W-1:0] rate_frac_o,
  output logic signed [pstr_pkg::PNOW_W-1:0] phase_now_o,
  output logic                              last_o
);

  // Configuration
  logic [pstr_pkg::SPS_W-1:0]  sps_q;
  logic [pstr_pkg::OSPS_W-1:0] osps_q;
  logic [pstr_pkg::GAIN_W-1:0] pgain_q, rgain_q;
  logic [pstr_pkg::MAXD_W-1:0] maxd_q;
  logic [pstr_pkg::RINT_W-1:0] rint_q;

  // Control state
  logic [pstr_pkg::LINE_AW-1:0] head_q, head_d;
  logic [pstr_pkg::FILL_W-1:0]  fill_q, fill_d;
  logic [pstr_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]                   j_q, j_d;
  logic [pstr_pkg::MAC_CW-1:0]  mac_q, mac_d;
  logic                         rdv_q;
  logic [pstr_pkg::SPS_W-1:0]   lp_q, lp_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [pstr_pkg::PH_W-1:0]   phase_q, phase_d;
  logic signed [pstr_pkg::RFR_W-1:0]  rate_q, rate_d;
  logic signed [pstr_pkg::ERR_W-1:0]  err_q, err_d;
  logic signed [pstr_pkg::W_W-1:0]    w_q, w_d;

  // Payload
  logic signed [pstr_pkg::RATE_W-1:0] ratew_q, ratew_d;
  logic signed [pstr_pkg::DA_W-1:0]   da_q, da_d, db_q, db_d;
  logic [pstr_pkg::ARM_W-1:0]         arm_q, arm_d;
  logic signed [pstr_pkg::AGE_W-1:0]  age0_q, age0_d;
  logic signed [pstr_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [pstr_pkg::SMP_W-1:0]  out0_q, out0_d;
  logic                               deriv_q, deriv_d;
  logic signed [pstr_pkg::SMP_W-1:0]  line_rd_q, tap_f_q, tap_d_q;
  logic                               zero_q;
  logic signed [pstr_pkg::SMP_W-1:0]  osmp_q;
  logic signed [pstr_pkg::ERR_W-1:0]  oerr_q;
  logic signed [pstr_pkg::RFR_W-1:0]  orate_q;
  logic signed [pstr_pkg::PNOW_W-1:0] ophase_q;
  logic                               olast_q;

  // Memories
  logic signed [pstr_pkg::SMP_W-1:0] line_mem [pstr_pkg::LINE_DEPTH];
  logic signed [pstr_pkg::SMP_W-1:0] filt_mem [pstr_pkg::TAP_DEPTH];
  logic signed [pstr_pkg::SMP_W-1:0] der_mem  [pstr_pkg::TAP_DEPTH];

  // Combinational helpers
  logic [1:0]                         nm1;
  logic signed [pstr_pkg::AGE_W-1:0]  age_raw;
  logic [pstr_pkg::LINE_AW-1:0]       age_cl, line_addr;
  logic [pstr_pkg::TAP_AW-1:0]        tap_addr;
  logic                               mac_issue;
  logic signed [pstr_pkg::SMP_W-1:0]  line_val, tap_val, y;
  logic signed [2*pstr_pkg::SMP_W-1:0] prod;
  logic signed [pstr_pkg::W_W-1:0]    q_wrap, w_wrap;
  logic signed [pstr_pkg::PH_W-1:0]   ph_wrapped, ph_step;
  logic signed [pstr_pkg::GAIN_W+pstr_pkg::ERR_W:0] gprod;
  logic [pstr_pkg::GAIN_W-1:0]        gsel;
  logic signed [pstr_pkg::RATE_W-1:0] lim, rate_clip;
  logic signed [pstr_pkg::W_W+1:0]    reload;

  // Outputs per symbol, clamped to 1..4
  always_comb begin
    if (osps_q == '0) begin
      nm1 = 2'd0;
    end else if (osps_q > 3'd4) begin
      nm1 = 2'd3;
    end else begin
      nm1 = 2'(osps_q - 3'd1);
    end
  end

  // Read addresses for the current tap
  assign mac_issue = !mac_q[pstr_pkg::TAP_M_W];
  assign age_raw   = age0_q + pstr_pkg::AGE_W'(mac_q);
  always_comb begin
    if (age_raw < 0) begin
      age_cl = '0;
    end else if (age_raw > pstr_pkg::AGE_MAX) begin
      age_cl = pstr_pkg::LINE_AW'(pstr_pkg::LINE_DEPTH - 1);
    end else begin
      age_cl = age_raw[pstr_pkg::LINE_AW-1:0];
    end
  end
  assign line_addr = head_q - age_cl;
  assign tap_addr  = {mac_q[pstr_pkg::TAP_M_W-1:0], arm_q};

  // Multiply-accumulate on registered reads
  assign line_val = zero_q ? '0 : line_rd_q;
  assign tap_val  = deriv_q ? tap_d_q : tap_f_q;
  assign prod     = tap_val * line_val;
  assign y        = pstr_pkg::round_sat(acc_q);

  // Phase helpers; the wrap count is signed, the phase may run below zero
  assign q_wrap     = pstr_pkg::W_W'($signed(phase_q[pstr_pkg::PH_W-1:pstr_pkg::WRAP_B]));
  assign w_wrap     = w_q + q_wrap;
  assign ph_wrapped = pstr_pkg::PH_W'({1'b0, phase_q[pstr_pkg::WRAP_B-1:0]});
  assign ph_step    = phase_q
                    + pstr_pkg::PH_W'({rint_q, {pstr_pkg::FRAC_W{1'b0}}})
                    + pstr_pkg::PH_W'(rate_q);

  // Loop gain product, shared by both increments
  assign gsel  = cmd_i.gain_a ? pgain_q : rgain_q;
  assign gprod = $signed({1'b0, gsel}) * err_q;

  // Rate clip and counter reload
  assign lim = pstr_pkg::RATE_W'(maxd_q);
  always_comb begin
    if (ratew_q > lim) begin
      rate_clip = lim;
    end else if (ratew_q < -lim) begin
      rate_clip = -lim;
    end else begin
      rate_clip = ratew_q;
    end
  end
  assign reload = (pstr_pkg::W_W + 2)'(w_wrap) + (pstr_pkg::W_W + 2)'(sps_q);

  // Next-state logic
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    cnt_d = cnt_q;
    j_d = j_q;
    mac_d = mac_q;
    lp_d = lp_q;
    phase_d = phase_q;
    rate_d = rate_q;
    err_d = err_q;
    w_d = w_q;
    ratew_d = ratew_q;
    da_d = da_q;
    db_d = db_q;
    arm_d = arm_q;
    age0_d = age0_q;
    acc_d = acc_q;
    out0_d = out0_q;
    deriv_d = deriv_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.push) begin
      head_d = head_q + 1'b1;
      if (fill_q != pstr_pkg::FILL_W'(pstr_pkg::LINE_DEPTH)) fill_d = fill_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.sym_start) begin
      j_d = '0;
      w_d = '0;
    end
    // Multiply-accumulate sweep
    if (mac_issue) mac_d = mac_q + 1'b1;
    if (rdv_q) acc_d = acc_q + pstr_pkg::ACC_W'(prod);
    if (cmd_i.wrap_start) begin
      w_d = w_wrap;
      phase_d = ph_wrapped;
      arm_d = phase_q[pstr_pkg::WRAP_B-1:pstr_pkg::FRAC_W];
      age0_d = pstr_pkg::AGE_W'(nm1) - pstr_pkg::AGE_W'(j_q) - pstr_pkg::AGE_W'(w_wrap);
      mac_d = '0;
      acc_d = '0;
      deriv_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      phase_d = ph_step;
      if (j_q == 2'd0) out0_d = y;
      j_d = j_q + 1'b1;
    end
    if (cmd_i.deriv_start) begin
      age0_d = pstr_pkg::AGE_W'(nm1) - pstr_pkg::AGE_W'(w_q);
      mac_d = '0;
      acc_d = '0;
      deriv_d = 1'b1;
    end
    if (cmd_i.calc_err) err_d = out0_q * y;
    if (cmd_i.gain_a) da_d = pstr_pkg::DA_W'((gprod + (1 <<< 29)) >>> 30);
    if (cmd_i.gain_b) begin
      db_d = pstr_pkg::DA_W'((gprod + (1 <<< 29)) >>> 30);
      lp_d = '0;
      ratew_d = pstr_pkg::RATE_W'(rate_q);
    end
    // One loop pass: rate first, then phase
    if (cmd_i.loop_step) begin
      ratew_d = ratew_q + pstr_pkg::RATE_W'(db_q);
      phase_d = phase_q + pstr_pkg::PH_W'(ratew_d) + pstr_pkg::PH_W'(da_q);
      lp_d = lp_q + 1'b1;
    end
    if (cmd_i.finish) begin
      rate_d = pstr_pkg::RFR_W'(rate_clip);
      phase_d = ph_wrapped;
      if (reload < 1) begin
        cnt_d = pstr_pkg::CNT_W'(1);
      end else if (reload > pstr_pkg::RELOAD_MAX) begin
        cnt_d = pstr_pkg::CNT_W'(63);
      end else begin
        cnt_d = reload[pstr_pkg::CNT_W-1:0];
      end
    end
    // Configuration write of the starting phase also loads the phase
    if (cfg_we_i && cfg_index_i == pstr_pkg::CFG_IPH) begin
      phase_d = pstr_pkg::PH_W'(cfg_wdata_i[pstr_pkg::IPH_W-1:0]);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q <= pstr_pkg::SPS_W'(2);
      osps_q <= pstr_pkg::OSPS_W'(1);
      pgain_q <= '0;
      rgain_q <= '0;
      maxd_q <= pstr_pkg::MAXD_W'(98304);
      rint_q <= '0;
      head_q <= '0;
      fill_q <= '0;
      cnt_q <= pstr_pkg::CNT_RESET;
      j_q <= '0;
      mac_q <= pstr_pkg::MAC_CW'(pstr_pkg::TAPS_PER_ARM);
      rdv_q <= 1'b0;
      lp_q <= '0;
      out_valid_q <= 1'b0;
      phase_q <= '0;
      rate_q <= '0;
      err_q <= '0;
      w_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pstr_pkg::CFG_SPS:   sps_q <= cfg_wdata_i[pstr_pkg::SPS_W-1:0];
          pstr_pkg::CFG_OSPS:  osps_q <= cfg_wdata_i[pstr_pkg::OSPS_W-1:0];
          pstr_pkg::CFG_PGAIN: pgain_q <= cfg_wdata_i[pstr_pkg::GAIN_W-1:0];
          pstr_pkg::CFG_RGAIN: rgain_q <= cfg_wdata_i[pstr_pkg::GAIN_W-1:0];
          pstr_pkg::CFG_MAXD:  maxd_q <= cfg_wdata_i[pstr_pkg::MAXD_W-1:0];
          pstr_pkg::CFG_RINT:  rint_q <= cfg_wdata_i[pstr_pkg::RINT_W-1:0];
          default: ;
        endcase
      end
      head_q <= head_d;
      fill_q <= fill_d;
      cnt_q <= cnt_d;
      j_q <= j_d;
      mac_q <= mac_d;
      rdv_q <= mac_issue;
      lp_q <= lp_d;
      out_valid_q <= out_valid_d;
      phase_q <= phase_d;
      rate_q <= rate_d;
      err_q <= err_d;
      w_q <= w_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ratew_q <= ratew_d;
    da_q <= da_d;
    db_q <= db_d;
    arm_q <= arm_d;
    age0_q <= age0_d;
    acc_q <= acc_d;
    out0_q <= out0_d;
    deriv_q <= deriv_d;
    zero_q <= ({1'b0, age_cl} >= fill_q);
    if (cmd_i.load_out) begin
      osmp_q <= y;
      oerr_q <= err_q;
      orate_q <= rate_q;
      ophase_q <= ph_step[pstr_pkg::PNOW_W-1:0];
      olast_q <= (j_q == nm1);
    end
  end

  // Delay line memory, newest sample at head
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) line_mem[head_d] <= sample_i;
    line_rd_q <= line_mem[line_addr];
  end

  // Tap memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_we && func_i == pstr_pkg::FN_TAP) filt_mem[tap_index_i] <= tap_value_i;
    tap_f_q <= filt_mem[tap_addr];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_we && func_i == pstr_pkg::FN_DTAP) der_mem[tap_index_i] <= tap_value_i;
    tap_d_q <= der_mem[tap_addr];
  end

  // Status
  assign status_o.fire      = (cnt_q == pstr_pkg::CNT_W'(1));
  assign status_o.mac_done  = !mac_issue && !rdv_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.last_out  = (j_q == nm1);
  assign status_o.loop_done = (lp_q == sps_q);

  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = osmp_q;
  assign timing_error_o = oerr_q;
  assign rate_frac_o    = orate_q;
  assign phase_now_o    = ophase_q;
  assign last_o         = olast_q;

`ifndef NO_ASSERTIONS
  // The symbol counter is never empty when a sample comes in
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> cnt_q != '0) else $error("symbol counter empty on push");
  // After the final wrap the phase sits in one filter span
  a_phase_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> phase_q[pstr_pkg::PH_W-1:pstr_pkg::WRAP_B] == '0)
    else $error("phase not wrapped");
  // Fill count never exceeds the line
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= pstr_pkg::FILL_W'(pstr_pkg::LINE_DEPTH)) else $error("fill overflow");
  // Rate estimate stays inside the clip after a symbol
  a_rate_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (pstr_pkg::RATE_W'(rate_q) <= lim) && (pstr_pkg::RATE_W'(rate_q) >= -lim))
    else $error("rate outside limit");
`endif

endmodule
